### rtl/cccc_pkg.sv
// shared types, constants and helpers for the coin credit channel controller
package cccc_pkg;

  localparam int unsigned NUM_CHANNELS = 64;
  localparam int unsigned CH_W         = 6;
  localparam int unsigned CREDIT_W     = 24;
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned RELOAD_W     = 8;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CH_W-1:0]     CH_LAST    = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  localparam logic [VALUE_W-1:0]  COIN_A_RESET     = 16'd100;
  localparam logic [VALUE_W-1:0]  COIN_B_RESET     = 16'd200;
  localparam logic [VALUE_W-1:0]  COIN_C_RESET     = 16'd500;
  localparam logic [VALUE_W-1:0]  BLINK_TH_RESET   = 16'd15;
  localparam logic [VALUE_W-1:0]  LINE_TH_RESET    = 16'd6;
  localparam logic [RELOAD_W-1:0] TICK_RELOAD_RESET = 8'd1;

  typedef enum logic [3:0] {
    OP_COIN        = 4'd0,
    OP_TICK        = 4'd1,
    OP_UP          = 4'd2,
    OP_DOWN        = 4'd3,
    OP_VIDEO_LOST  = 4'd4,
    OP_ON          = 4'd5,
    OP_OFF         = 4'd6,
    OP_SERVICE_IN  = 4'd7,
    OP_SERVICE_OUT = 4'd8,
    OP_IDLE        = 4'd9
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COIN_A      = 3'd0,
    CFG_COIN_B      = 3'd1,
    CFG_COIN_C      = 3'd2,
    CFG_BLINK_TH    = 3'd3,
    CFG_LINE_TH     = 3'd4,
    CFG_TICK_RELOAD = 3'd5
  } cfg_idx_e;

  // the last code is a coin kind that the booth refuses
  typedef enum logic [1:0] {
    KIND_A    = 2'd0,
    KIND_B    = 2'd1,
    KIND_C    = 2'd2,
    KIND_NONE = 2'd3
  } coin_kind_e;

  function automatic logic [3:0] rev4(input logic [3:0] v);
    rev4 = {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

### rtl/coin_credit_channel_controller_unit.sv
// coin credit and channel controller for a pay video booth
// an accepted item's result is registered at the accept edge
// throughput: one item per cycle; the booth state updates at the accept edge, so
//   the next item sees it with no bubble, and the output register lets a new item
//   in while the previous result is taken in the same cycle, else input stalls
// reset: async active low, booth off, zero credit, channel 0, registers at defaults
module coin_credit_channel_controller_unit import cccc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VALUE_W-1:0]   cfg_data_i,
  // event input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3:0]           op_i,
  input  logic [1:0]           coin_kind_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 booth_active_o,
  output logic [CREDIT_W-1:0]  credit_o,
  output logic [CH_W-1:0]      channel_o,
  output logic                 coin_line_o,
  output logic                 low_credit_blink_o,
  output logic [2:0]           last_coin_flags_o,
  output logic                 service_active_o,
  output logic [7:0]           matrix_low_byte_o,
  output logic [3:0]           matrix_high_nibble_o
);

  // configuration registers
  logic [VALUE_W-1:0]  coin_a_q, coin_b_q, coin_c_q;
  logic [VALUE_W-1:0]  blink_th_q, line_th_q;
  logic [RELOAD_W-1:0] tick_reload_q;

  // booth state
  logic                active_q, active_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [RELOAD_W-1:0] prescale_q, prescale_d;
  logic [CH_W-1:0]     chan_q, chan_d;
  logic                dir_down_q, dir_down_d;
  logic                service_q, service_d;
  logic                blink_q, blink_d;
  logic                line_q, line_d;
  logic [2:0]          flags_q, flags_d;

  // result register
  logic                out_valid_q;
  logic [7:0]          mlow_q, mlow_d;
  logic [3:0]          mhigh_q, mhigh_d;
  logic                act_out_q;
  logic [CREDIT_W-1:0] credit_out_q;
  logic [CH_W-1:0]     chan_out_q;
  logic                line_out_q, blink_out_q, service_out_q;
  logic [2:0]          flags_out_q;

  logic                accept;
  logic [VALUE_W-1:0]  coin_add;
  logic [CREDIT_W:0]   coin_sum;
  logic [CREDIT_W-1:0] credit_dec;
  logic                step_en;
  logic                step_down;
  logic [3:0]          cs;

  // output register frees up when empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_a_q      <= COIN_A_RESET;
      coin_b_q      <= COIN_B_RESET;
      coin_c_q      <= COIN_C_RESET;
      blink_th_q    <= BLINK_TH_RESET;
      line_th_q     <= LINE_TH_RESET;
      tick_reload_q <= TICK_RELOAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COIN_A:      coin_a_q      <= cfg_data_i;
        CFG_COIN_B:      coin_b_q      <= cfg_data_i;
        CFG_COIN_C:      coin_c_q      <= cfg_data_i;
        CFG_BLINK_TH:    blink_th_q    <= cfg_data_i;
        CFG_LINE_TH:     line_th_q     <= cfg_data_i;
        CFG_TICK_RELOAD: tick_reload_q <= cfg_data_i[RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // coin value select and saturating add
  always_comb begin
    case (coin_kind_e'(coin_kind_i))
      KIND_A:  coin_add = coin_a_q;
      KIND_B:  coin_add = coin_b_q;
      default: coin_add = coin_c_q;
    endcase
  end

  assign coin_sum   = {1'b0, credit_q} + {{(CREDIT_W + 1 - VALUE_W){1'b0}}, coin_add};
  assign credit_dec = credit_q - CREDIT_W'(1);

  // next booth state for the current item
  always_comb begin
    active_d   = active_q;
    credit_d   = credit_q;
    prescale_d = prescale_q;
    chan_d     = chan_q;
    dir_down_d = dir_down_q;
    service_d  = service_q;
    blink_d    = blink_q;
    line_d     = line_q;
    flags_d    = flags_q;
    step_en    = 1'b0;
    step_down  = dir_down_q;

    case (op_e'(op_i))
      OP_COIN: begin
        if (!service_q && coin_kind_e'(coin_kind_i) != KIND_NONE) begin
          if (!active_q) begin
            chan_d   = '0;
            active_d = 1'b1;
          end
          credit_d = coin_sum[CREDIT_W] ? CREDIT_MAX : coin_sum[CREDIT_W-1:0];
          line_d   = 1'b1;
          blink_d  = 1'b0;
          flags_d  = 3'(1) << coin_kind_i;
        end
      end
      OP_TICK: begin
        if (!service_q) begin
          if (prescale_q == '0) begin
            prescale_d = tick_reload_q;
            if (active_q) begin
              if (credit_q == '0) begin
                // out of credit: booth switches off, prescaler still reloaded
                active_d   = 1'b0;
                chan_d     = '0;
                dir_down_d = 1'b0;
                service_d  = 1'b0;
                blink_d    = 1'b0;
                line_d     = 1'b0;
                flags_d    = '0;
              end else begin
                credit_d = credit_dec;
                if (credit_dec < {{(CREDIT_W - VALUE_W){1'b0}}, blink_th_q}) begin
                  blink_d = 1'b1;
                end
                if (credit_dec < {{(CREDIT_W - VALUE_W){1'b0}}, line_th_q}) begin
                  line_d = 1'b0;
                end
              end
            end
          end else begin
            prescale_d = prescale_q - RELOAD_W'(1);
          end
        end
      end
      OP_UP, OP_DOWN: begin
        if (active_q) begin
          dir_down_d = (op_e'(op_i) == OP_DOWN);
          step_down  = (op_e'(op_i) == OP_DOWN);
          step_en    = 1'b1;
        end
      end
      OP_VIDEO_LOST: begin
        step_en = active_q;
      end
      OP_ON: begin
        active_d = 1'b1;
      end
      OP_OFF: begin
        active_d   = 1'b0;
        credit_d   = '0;
        chan_d     = '0;
        dir_down_d = 1'b0;
        service_d  = 1'b0;
        blink_d    = 1'b0;
        line_d     = 1'b0;
        flags_d    = '0;
      end
      OP_SERVICE_IN: begin
        if (!service_q) begin
          service_d = 1'b1;
          chan_d    = '0;
          active_d  = 1'b1;
        end
      end
      OP_SERVICE_OUT: begin
        if (service_q) begin
          active_d   = 1'b0;
          credit_d   = '0;
          chan_d     = '0;
          dir_down_d = 1'b0;
          service_d  = 1'b0;
          blink_d    = 1'b0;
          line_d     = 1'b0;
          flags_d    = '0;
        end
      end
      default: ;
    endcase

    // channel step with wrap over the channel count, clears coin flags
    if (step_en) begin
      if (step_down) begin
        chan_d = (chan_q == '0) ? CH_LAST : chan_q - CH_W'(1);
      end else begin
        chan_d = (chan_q >= CH_LAST) ? '0 : chan_q + CH_W'(1);
      end
      flags_d = '0;
    end
  end

  // video matrix word from the new channel, blank while the booth is off
  assign cs = rev4(4'(1) << chan_d[5:4]);

  always_comb begin
    if (active_d) begin
      mlow_d  = {rev4(chan_d[3:0]), cs};
      mhigh_d = cs;
    end else begin
      mlow_d  = '0;
      mhigh_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      credit_q    <= '0;
      prescale_q  <= '0;
      chan_q      <= '0;
      dir_down_q  <= 1'b0;
      service_q   <= 1'b0;
      blink_q     <= 1'b0;
      line_q      <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        active_q    <= active_d;
        credit_q    <= credit_d;
        prescale_q  <= prescale_d;
        chan_q      <= chan_d;
        dir_down_q  <= dir_down_d;
        service_q   <= service_d;
        blink_q     <= blink_d;
        line_q      <= line_d;
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_out_q     <= active_d;
      credit_out_q  <= credit_d;
      chan_out_q    <= chan_d;
      line_out_q    <= line_d;
      blink_out_q   <= blink_d;
      flags_out_q   <= flags_d;
      service_out_q <= service_d;
      mlow_q        <= mlow_d;
      mhigh_q       <= mhigh_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign booth_active_o       = act_out_q;
  assign credit_o             = credit_out_q;
  assign channel_o            = chan_out_q;
  assign coin_line_o          = line_out_q;
  assign low_credit_blink_o   = blink_out_q;
  assign last_coin_flags_o    = flags_out_q;
  assign service_active_o     = service_out_q;
  assign matrix_low_byte_o    = mlow_q;
  assign matrix_high_nibble_o = mhigh_q;

endmodule

### verif/booth_scoreboard_pkg.sv
`timescale 1ns / 1ps
// booth state predictor and result scoreboard for the controller testbench
package booth_scoreboard_pkg;
  import cccc_pkg::*;

  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic                booth_active;
    logic [CREDIT_W-1:0] credit;
    logic [CH_W-1:0]     channel;
    logic                coin_line;
    logic                blink;
    logic [2:0]          coin_flags;
    logic                service;
    logic [7:0]          matrix_low;
    logic [3:0]          matrix_high;
  } booth_view_t;

  class booth_tracker;
    logic [VALUE_W-1:0]  coin_value [3];
    logic [VALUE_W-1:0]  blink_th;
    logic [VALUE_W-1:0]  line_th;
    logic [RELOAD_W-1:0] reload;

    logic                active;
    logic [CREDIT_W-1:0] credit;
    logic [RELOAD_W-1:0] prescale;
    logic [CH_W-1:0]     chan;
    logic                dir_down;
    logic                service;
    logic                blink;
    logic                line;
    logic [2:0]          flags;

    booth_view_t expected_views [$];
    int unsigned mismatches;
    int unsigned compared;
    int unsigned events_noted;
    int unsigned shutdowns;

    function new();
      coin_value[0] = COIN_A_RESET;
      coin_value[1] = COIN_B_RESET;
      coin_value[2] = COIN_C_RESET;
      blink_th      = BLINK_TH_RESET;
      line_th       = LINE_TH_RESET;
      reload        = TICK_RELOAD_RESET;
      prescale      = '0;
      power_down();
      mismatches    = 0;
      compared      = 0;
      events_noted  = 0;
      shutdowns     = 0;
    endfunction

    // prescaler survives a switch off
    function void power_down();
      active   = 1'b0;
      credit   = '0;
      chan     = '0;
      dir_down = 1'b0;
      service  = 1'b0;
      blink    = 1'b0;
      line     = 1'b0;
      flags    = '0;
    endfunction

    function logic [3:0] flip4(input logic [3:0] v);
      logic [3:0] r;
      for (int i = 0; i < 4; i++) r[i] = v[3-i];
      return r;
    endfunction

    function void step_channel(input logic down);
      if (down) chan = (chan == '0) ? CH_LAST : chan - CH_W'(1);
      else chan = (chan >= CH_LAST) ? '0 : chan + CH_W'(1);
      flags = '0;
    endfunction

    function void write_register(input cfg_idx_e idx, input logic [VALUE_W-1:0] data);
      case (idx)
        CFG_COIN_A:      coin_value[0] = data;
        CFG_COIN_B:      coin_value[1] = data;
        CFG_COIN_C:      coin_value[2] = data;
        CFG_BLINK_TH:    blink_th = data;
        CFG_LINE_TH:     line_th = data;
        CFG_TICK_RELOAD: reload = data[RELOAD_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the booth by one event and queue the view it produces
    function void note_event(input logic [3:0] op, input logic [1:0] kind);
      logic [CREDIT_W:0] sum;
      logic [3:0]        sel;
      booth_view_t       v;
      events_noted++;
      case (op)
        OP_COIN: begin
          if (!service && kind != KIND_NONE) begin
            sum = {1'b0, credit} + {{(CREDIT_W + 1 - VALUE_W){1'b0}}, coin_value[kind]};
            if (!active) begin
              chan   = '0;
              active = 1'b1;
            end
            credit = sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
            line   = 1'b1;
            blink  = 1'b0;
            flags  = 3'b001 << kind;
          end
        end
        OP_TICK: begin
          if (!service) begin
            if (prescale == '0) begin
              if (active) begin
                if (credit == '0) begin
                  power_down();
                  shutdowns++;
                end else begin
                  credit = credit - CREDIT_W'(1);
                  if (credit < CREDIT_W'(blink_th)) blink = 1'b1;
                  if (credit < CREDIT_W'(line_th)) line = 1'b0;
                end
              end
              prescale = reload;
            end else begin
              prescale = prescale - RELOAD_W'(1);
            end
          end
        end
        OP_UP, OP_DOWN: begin
          if (active) begin
            dir_down = (op == OP_DOWN);
            step_channel(dir_down);
          end
        end
        OP_VIDEO_LOST: if (active) step_channel(dir_down);
        OP_ON:         active = 1'b1;
        OP_OFF:        power_down();
        OP_SERVICE_IN: begin
          if (!service) begin
            service = 1'b1;
            chan    = '0;
            active  = 1'b1;
          end
        end
        OP_SERVICE_OUT: if (service) power_down();
        default: ;
      endcase

      v.booth_active = active;
      v.credit       = credit;
      v.channel      = chan;
      v.coin_line    = line;
      v.blink        = blink;
      v.coin_flags   = flags;
      v.service      = service;
      if (active) begin
        sel           = flip4(4'b0001 << chan[5:4]);
        v.matrix_low  = {flip4(chan[3:0]), sel};
        v.matrix_high = sel;
      end else begin
        v.matrix_low  = '0;
        v.matrix_high = '0;
      end
      expected_views.push_back(v);
    endfunction

    function void compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input booth_view_t got);
      booth_view_t want;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual credit 0x%0h channel %0d",
                   $time, got.credit, got.channel);
        return;
      end
      want = expected_views.pop_front();
      compared++;
      compare_field("booth_active", want.booth_active, got.booth_active);
      compare_field("credit", want.credit, got.credit);
      compare_field("channel", want.channel, got.channel);
      compare_field("coin_line", want.coin_line, got.coin_line);
      compare_field("low_credit_blink", want.blink, got.blink);
      compare_field("last_coin_flags", want.coin_flags, got.coin_flags);
      compare_field("service_active", want.service, got.service);
      compare_field("matrix_low_byte", want.matrix_low, got.matrix_low);
      compare_field("matrix_high_nibble", want.matrix_high, got.matrix_high);
    endfunction
  endclass

endpackage

### verif/coin_credit_channel_controller_unit_tb.sv
`timescale 1ns / 1ps
// top-level testbench for the coin credit channel controller
module coin_credit_channel_controller_unit_tb;
  import cccc_pkg::*;
  import booth_scoreboard_pkg::*;

  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES   = 4;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned IDLE_LIMIT     = 1000;
  // covers the output register, plus margin
  localparam int unsigned SETTLE_CYCLES  = 3;
  localparam int unsigned DIRECTED_COUNT = 24;
  // highest op code, decoded as no change
  localparam logic [3:0]  OP_NOISE_MAX   = 4'd15;

  typedef enum int unsigned {RX_OPEN, RX_COIN_FLIP, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [VALUE_W-1:0]   cfg_data  = '0;
  logic                 ev_valid  = 1'b0;
  logic [3:0]           ev_op     = OP_IDLE;
  logic [1:0]           ev_kind   = KIND_A;
  logic                 res_ready = 1'b0;

  logic                 ev_ready;
  logic                 res_valid;
  logic                 booth_active;
  logic [CREDIT_W-1:0]  credit;
  logic [CH_W-1:0]      channel;
  logic                 coin_line;
  logic                 low_credit_blink;
  logic [2:0]           last_coin_flags;
  logic                 service_active;
  logic [7:0]           matrix_low_byte;
  logic [3:0]           matrix_high_nibble;
  booth_view_t          seen;

  booth_tracker booth;
  int unsigned  items_sent      = 0;
  int unsigned  settings_loaded = 0;
  int unsigned  idle_cycles     = 0;
  rx_mode_e     rx_mode         = RX_OPEN;
  int unsigned  rx_left         = 0;

  // short directed walk under the reset settings: every op, coins of all
  // kinds and the refused kind, channel wrap below zero, service entry and
  // its repeats, service exit inside and outside service, switch on with no
  // credit and the tick that then finds zero credit
  logic [3:0] dir_ops [DIRECTED_COUNT] = '{
    OP_IDLE, OP_TICK, OP_UP, OP_COIN, OP_COIN, OP_COIN, OP_COIN, OP_DOWN,
    OP_VIDEO_LOST, OP_UP, OP_VIDEO_LOST, OP_NOISE_MAX, OP_SERVICE_IN, OP_COIN,
    OP_TICK, OP_SERVICE_IN, OP_UP, OP_SERVICE_OUT, OP_SERVICE_OUT, OP_ON,
    OP_TICK, OP_TICK, OP_ON, OP_OFF
  };
  logic [1:0] dir_kinds [DIRECTED_COUNT] = '{
    KIND_A, KIND_A, KIND_B, KIND_A, KIND_B, KIND_C, KIND_NONE, KIND_C,
    KIND_A, KIND_B, KIND_A, KIND_NONE, KIND_A, KIND_A,
    KIND_B, KIND_C, KIND_A, KIND_A, KIND_B, KIND_A,
    KIND_A, KIND_B, KIND_C, KIND_NONE
  };

  coin_credit_channel_controller_unit dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (ev_valid),
    .in_ready_o           (ev_ready),
    .op_i                 (ev_op),
    .coin_kind_i          (ev_kind),
    .out_valid_o          (res_valid),
    .out_ready_i          (res_ready),
    .booth_active_o       (booth_active),
    .credit_o             (credit),
    .channel_o            (channel),
    .coin_line_o          (coin_line),
    .low_credit_blink_o   (low_credit_blink),
    .last_coin_flags_o    (last_coin_flags),
    .service_active_o     (service_active),
    .matrix_low_byte_o    (matrix_low_byte),
    .matrix_high_nibble_o (matrix_high_nibble)
  );

  // field order matches booth_view_t
  assign seen = {booth_active, credit, channel, coin_line, low_credit_blink,
                 last_coin_flags, service_active, matrix_low_byte, matrix_high_nibble};

  always #(HALF_PERIOD) clk = ~clk;

  // monitor: values read here are the ones from just before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      // the result taken now belongs to an older item, so check before noting
      if (res_valid && res_ready) booth.check_result(seen);
      if (ev_valid && ev_ready) booth.note_event(ev_op, ev_kind);
      if ((ev_valid && ev_ready) || (res_valid && res_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: switches at random between open, coin-flip, sparse and
  // periodic stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(RX_OPEN, RX_PERIODIC));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:      res_ready <= 1'b1;
      RX_COIN_FLIP: res_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:    res_ready <= ($urandom_range(0, 3) == 0);
      default:      res_ready <= (rx_left[1:0] != 2'b00);
    endcase
  end

  // hang detector
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // present one item and hold it until taken; ready only moves at the rising
  // edge, so the value seen at the falling edge decides the next accept
  task automatic send_event(input logic [3:0] op, input logic [1:0] kind);
    ev_valid <= 1'b1;
    ev_op    <= op;
    ev_kind  <= kind;
    @(negedge clk);
    while (!ev_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait until every queued view has been checked
  task automatic drain();
    ev_valid <= 1'b0;
    @(posedge clk);
    while (booth.expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six registers back to back, only while the booth is drained
  task automatic load_setting(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                              input logic [VALUE_W-1:0] c, input logic [VALUE_W-1:0] blink_th,
                              input logic [VALUE_W-1:0] line_th,
                              input logic [VALUE_W-1:0] reload);
    logic [VALUE_W-1:0] vals [6];
    cfg_idx_e           idx;
    vals[CFG_COIN_A]      = a;
    vals[CFG_COIN_B]      = b;
    vals[CFG_COIN_C]      = c;
    vals[CFG_BLINK_TH]    = blink_th;
    vals[CFG_LINE_TH]     = line_th;
    vals[CFG_TICK_RELOAD] = reload;
    idx = CFG_COIN_A;
    cfg_we <= 1'b1;
    forever begin
      cfg_idx  <= idx;
      cfg_data <= vals[idx];
      booth.write_register(idx, vals[idx]);
      @(posedge clk);
      if (idx == CFG_TICK_RELOAD) break;
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // event mix: a booth session is coins, ticks and channel moves; calm mode
  // keeps the booth switched on so credit can build up to saturation
  function automatic logic [3:0] pick_op(input int unsigned coin_pct, input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < coin_pct) return OP_COIN;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_TICK;
    if (r < 57) return OP_UP;
    if (r < 67) return OP_DOWN;
    if (r < 75) return OP_VIDEO_LOST;
    if (calm) return OP_TICK;
    if (r < 80) return OP_ON;
    if (r < 84) return OP_OFF;
    if (r < 88) return OP_SERVICE_IN;
    if (r < 93) return OP_SERVICE_OUT;
    return 4'($urandom_range(OP_IDLE, OP_NOISE_MAX));
  endfunction

  // random bursts with random gaps; idle and undecoded ops are not counted
  task automatic run_random(input int unsigned count, input int unsigned coin_pct,
                            input bit calm);
    int unsigned burst;
    int unsigned gap;
    int unsigned done;
    logic [3:0]  op;
    logic [1:0]  kind;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && done < count) begin
        op   = pick_op(coin_pct, calm);
        kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(KIND_A, KIND_C));
        send_event(op, kind);
        if (op < OP_IDLE) done++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // now and then hold off until the booth has answered everything
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end else if (gap != 0) begin
        ev_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    booth = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk under reset settings, sent back to back
    for (int i = 0; i < DIRECTED_COUNT; i++) send_event(dir_ops[i], dir_kinds[i]);
    drain();

    // tiny coins and no prescale: credit runs dry, blinks and drops the line
    load_setting(16'd3, 16'd7, 16'd20, 16'd5, 16'd2, 16'd0);
    run_random(150, 25, 1'b0);
    drain();

    // everything at maximum: coins saturate the credit, slowest prescale
    load_setting('1, '1, '1, '1, '1, '1);
    run_random(300, 95, 1'b1);
    drain();

    // everything at zero: coins add nothing, no prescale, credit only drains
    load_setting('0, '0, '0, '0, '0, '0);
    run_random(100, 20, 1'b0);
    drain();

    // random settings, alternating a low-credit range and the full range
    for (int p = 0; p < 4; p++) begin
      if (p % 2 == 0)
        load_setting(VALUE_W'($urandom_range(0, 40)), VALUE_W'($urandom_range(0, 40)),
                     VALUE_W'($urandom_range(0, 40)), VALUE_W'($urandom_range(0, 60)),
                     VALUE_W'($urandom_range(0, 60)), VALUE_W'($urandom_range(0, 3)));
      else
        load_setting(VALUE_W'($urandom_range(0, 65535)), VALUE_W'($urandom_range(0, 65535)),
                     VALUE_W'($urandom_range(0, 65535)), VALUE_W'($urandom_range(0, 65535)),
                     VALUE_W'($urandom_range(0, 65535)), VALUE_W'($urandom_range(0, 65535)));
      run_random(150, 20, 1'b0);
      drain();
    end

    $display("sent %0d events over %0d register settings, %0d results compared",
             items_sent, settings_loaded, booth.compared);
    $display("zero-credit switch-offs seen: %0d, mismatches: %0d",
             booth.shutdowns, booth.mismatches);
    if (booth.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/cccc_pkg.sv
rtl/coin_credit_channel_controller_unit.sv
verif/booth_scoreboard_pkg.sv
verif/coin_credit_channel_controller_unit_tb.sv
